// ===== rtl/core/websocket_frame_deframer_macros.svh =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer assertion macros
// Shared property forms for the deframer's checks, clocked on aclk and held
// off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WSDF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WSDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/wsdf_pkg.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer package
// Header field masks, length escapes, opcodes and action codes.
// ----------------------------------------------------------------------------
package wsdf_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_W   = 64;
    localparam int unsigned KEY_W   = 32;
    localparam int unsigned OPC_W   = 4;
    localparam int unsigned ACT_W   = 2;
    localparam int unsigned HCNT_W  = 3;
    localparam int unsigned MIDX_W  = 2;

    // First and second header byte fields.
    localparam logic [BYTE_W-1:0] FLAG_BIT_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] OPCODE_MASK   = 8'h0F;
    localparam logic [BYTE_W-1:0] LEN7_MASK     = 8'h7F;

    // Seven-bit length escapes.
    localparam logic [BYTE_W-1:0] LEN_ESC_16 = 8'd126;
    localparam logic [BYTE_W-1:0] LEN_ESC_64 = 8'd127;

    // Byte counts of the extended length and mask key fields.
    localparam logic [HCNT_W-1:0] LEN16_BYTES = 3'd2;
    localparam logic [HCNT_W-1:0] KEY_BYTES   = 3'd4;

    // Opcodes that lead to an action.
    localparam logic [OPC_W-1:0] OPC_TEXT  = 4'h1;
    localparam logic [OPC_W-1:0] OPC_CLOSE = 4'h8;
    localparam logic [OPC_W-1:0] OPC_PING  = 4'h9;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE    = 2'd0,
        ACT_DELIVER = 2'd1,
        ACT_PONG    = 2'd2,
        ACT_CLOSE   = 2'd3
    } action_t;

endpackage

// ===== rtl/core/websocket_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses one WebSocket frame per received buffer and streams its unmasked
// payload.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel carries the received buffer one byte per transfer, with
// s_tdata holding the raw byte and s_tlast marking the buffer's last byte.
// The master channel carries at most one result per input transfer: m_tuser
// flags a payload byte, m_tlast flags frame completion, and m_tdata carries
// the byte, the truncation flag, opcode, FIN bit and the completion action.
// Header bytes and the mask key give no result unless the frame completes
// or the buffer ends on them; trailing bytes after the frame give none.
// A result appears on the master side in the cycle after the byte that
// caused it is transferred. Throughput is one byte per cycle unless the
// receiver stalls; parser state and output register each update once per
// transfer, and the widest path is the 64-bit length decrement and compare.
// The output register doubles as the hand-off stage: a new byte is taken
// whenever that register is empty or being emptied in the same cycle, so a
// stalled receiver holds the input back after one result.
// Reset (aresetn low at a clock edge) returns the parser to the first header
// byte, clears all captured header fields and empties the output register.
// ----------------------------------------------------------------------------
`include "websocket_frame_deframer_macros.svh"

module websocket_frame_deframer (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tlast,   // buffer_end

    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] payload_byte, [8] truncated, [12:9] frame_opcode, [13] fin_flag,
    // [15:14] action
    output logic [15:0] m_tdata,
    output logic        m_tuser,   // has_byte
    output logic        m_tlast    // frame_done
);

    typedef enum logic [2:0] {
        PH_B0   = 3'd0,
        PH_B1   = 3'd1,
        PH_L16  = 3'd2,
        PH_L64  = 3'd3,
        PH_MASK = 3'd4,
        PH_PAY  = 3'd5,
        PH_DISC = 3'd6
    } phase_t;

    // Parser state.
    phase_t                           phase_reg,  phase_next;
    logic [wsdf_pkg::OPC_W-1:0]       opcode_reg, opcode_next;
    logic                             fin_reg,    fin_next;
    logic                             masked_reg, masked_next;
    logic [wsdf_pkg::LEN_W-1:0]       len_reg,    len_next;
    logic [wsdf_pkg::HCNT_W-1:0]      hcnt_reg,   hcnt_next;
    logic [wsdf_pkg::KEY_W-1:0]       key_reg,    key_next;
    logic [wsdf_pkg::MIDX_W-1:0]      midx_reg,   midx_next;

    // Output register.
    logic        m_tvalid_reg;
    logic [15:0] m_tdata_reg;
    logic        m_tuser_reg;
    logic        m_tlast_reg;

    logic                            in_xfer;
    logic                            has_c, done_c, trunc_c;
    logic [wsdf_pkg::BYTE_W-1:0]     pbyte_c;
    logic [wsdf_pkg::BYTE_W-1:0]     key_byte_c;
    wsdf_pkg::action_t               act_c;
    logic [wsdf_pkg::LEN_W-1:0]      len_shift_c;
    logic [wsdf_pkg::HCNT_W-1:0]     hcnt_inc_c;
    logic [wsdf_pkg::BYTE_W-1:0]     len7_c;

    // The output register is free when it is empty or being drained.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;

    assign len_shift_c = {len_reg[wsdf_pkg::LEN_W-wsdf_pkg::BYTE_W-1:0], s_tdata};
    assign hcnt_inc_c  = hcnt_reg + 3'd1;
    assign len7_c      = s_tdata & wsdf_pkg::LEN7_MASK;

    // Mask key byte for the current payload position; key byte zero sits in
    // the top bits of the key register.
    always_comb begin
        case (midx_reg)
            2'd0:    key_byte_c = key_reg[31:24];
            2'd1:    key_byte_c = key_reg[23:16];
            2'd2:    key_byte_c = key_reg[15:8];
            default: key_byte_c = key_reg[7:0];
        endcase
    end

    // Next-state logic for one accepted byte.
    always_comb begin
        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        fin_next    = fin_reg;
        masked_next = masked_reg;
        len_next    = len_reg;
        hcnt_next   = hcnt_reg;
        key_next    = key_reg;
        midx_next   = midx_reg;
        has_c       = 1'b0;
        done_c      = 1'b0;
        trunc_c     = 1'b0;
        pbyte_c     = '0;
        act_c       = wsdf_pkg::ACT_NONE;

        case (phase_reg)
            PH_B0: begin
                fin_next    = |(s_tdata & wsdf_pkg::FLAG_BIT_MASK);
                opcode_next = s_tdata[wsdf_pkg::OPC_W-1:0];
                phase_next  = PH_B1;
            end
            PH_B1: begin
                masked_next = |(s_tdata & wsdf_pkg::FLAG_BIT_MASK);
                hcnt_next   = '0;
                key_next    = '0;
                midx_next   = '0;
                len_next    = '0;
                if (len7_c == wsdf_pkg::LEN_ESC_16) begin
                    phase_next = PH_L16;
                end else if (len7_c == wsdf_pkg::LEN_ESC_64) begin
                    phase_next = PH_L64;
                end else begin
                    len_next = {{(wsdf_pkg::LEN_W-wsdf_pkg::BYTE_W){1'b0}}, len7_c};
                    if (s_tdata[7]) begin
                        phase_next = PH_MASK;
                    end else if (len7_c == '0) begin
                        done_c = 1'b1;
                    end else begin
                        phase_next = PH_PAY;
                    end
                end
            end
            PH_L16, PH_L64: begin
                len_next  = len_shift_c;
                hcnt_next = hcnt_inc_c;
                // The 64-bit field ends when the three-bit count wraps.
                if ((phase_reg == PH_L16 && hcnt_inc_c >= wsdf_pkg::LEN16_BYTES) ||
                    hcnt_inc_c == '0) begin
                    hcnt_next = '0;
                    if (masked_reg) begin
                        phase_next = PH_MASK;
                    end else begin
                        midx_next = '0;
                        if (len_shift_c == '0) begin
                            done_c = 1'b1;
                        end else begin
                            phase_next = PH_PAY;
                        end
                    end
                end
            end
            PH_MASK: begin
                key_next  = {key_reg[wsdf_pkg::KEY_W-wsdf_pkg::BYTE_W-1:0], s_tdata};
                hcnt_next = hcnt_inc_c;
                if (hcnt_inc_c >= wsdf_pkg::KEY_BYTES) begin
                    hcnt_next = '0;
                    midx_next = '0;
                    if (len_reg == '0) begin
                        done_c = 1'b1;
                    end else begin
                        phase_next = PH_PAY;
                    end
                end
            end
            PH_PAY: begin
                has_c     = 1'b1;
                pbyte_c   = masked_reg ? (s_tdata ^ key_byte_c) : s_tdata;
                midx_next = midx_reg + 2'd1;
                len_next  = len_reg - 64'd1;
                done_c    = (len_reg == 64'd1);
            end
            PH_DISC: begin
                phase_next = PH_DISC;
            end
            default: begin
                phase_next = PH_B0;
            end
        endcase

        if (done_c) begin
            if (opcode_reg == wsdf_pkg::OPC_TEXT) begin
                act_c = wsdf_pkg::ACT_DELIVER;
            end else if (opcode_reg == wsdf_pkg::OPC_PING) begin
                act_c = wsdf_pkg::ACT_PONG;
            end else if (opcode_reg == wsdf_pkg::OPC_CLOSE) begin
                act_c = wsdf_pkg::ACT_CLOSE;
            end
            phase_next = s_tlast ? PH_B0 : PH_DISC;
        end else if (s_tlast) begin
            // A buffer that ends inside the frame truncates it; one that ends
            // among trailing bytes just rearms the parser.
            trunc_c    = (phase_reg != PH_DISC);
            phase_next = PH_B0;
            hcnt_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_B0;
            opcode_reg   <= '0;
            fin_reg      <= 1'b0;
            masked_reg   <= 1'b0;
            len_reg      <= '0;
            hcnt_reg     <= '0;
            key_reg      <= '0;
            midx_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (in_xfer) begin
                phase_reg  <= phase_next;
                opcode_reg <= opcode_next;
                fin_reg    <= fin_next;
                masked_reg <= masked_next;
                len_reg    <= len_next;
                hcnt_reg   <= hcnt_next;
                key_reg    <= key_next;
                midx_reg   <= midx_next;
            end
            if (in_xfer) begin
                m_tvalid_reg <= has_c || done_c || trunc_c;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Result payload; loaded on every transfer, read only while valid.
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            m_tdata_reg <= {act_c, fin_next, opcode_next, trunc_c, pbyte_c};
            m_tuser_reg <= has_c;
            m_tlast_reg <= done_c;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // An action is only ever reported together with frame completion.
    `WSDF_ASSERT_SAME(a_act_only_done, m_tvalid && !m_tlast, m_tdata[15:14] == 2'd0,
                      "action without frame completion")

    // A frame cannot both complete and be truncated.
    `WSDF_ASSERT_SAME(a_done_xor_trunc, m_tvalid, !(m_tlast && m_tdata[8]),
                      "frame done and truncated together")

    // While streaming payload there is always at least one byte left.
    `WSDF_ASSERT_SAME(a_pay_len_nonzero, phase_reg == PH_PAY, len_reg != '0,
                      "payload phase with zero length")

    // The mask key is only collected for masked frames.
    `WSDF_ASSERT_SAME(a_mask_needs_flag, phase_reg == PH_MASK, masked_reg,
                      "mask key phase on an unmasked frame")

    // A payload byte transfer always yields a result carrying that byte.
    `WSDF_ASSERT_NEXT(a_pay_gives_byte, in_xfer && phase_reg == PH_PAY, m_tvalid && m_tuser,
                      "payload byte without result")

endmodule
